@@ rtl/core/chorus_modulated_delay_assert.svh @@
// assertion macros used by the checker file
`ifndef CHORUS_MODULATED_DELAY_ASSERT_SVH
`define CHORUS_MODULATED_DELAY_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define CMD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define CMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/cmd_pkg.sv @@
package cmd_pkg;

    localparam int BUF_DEPTH_DEF  = 2048;
    localparam int SINE_DEPTH_DEF = 256;
    localparam int SAMPLE_W_DEF   = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;
    localparam int CENTER_W   = 19;
    localparam int DEPTH_W    = 19;
    localparam int STEP_W     = 23;
    localparam int MIX_W      = 17;
    localparam int PHASE_W    = 24;
    localparam int SINE_W     = 15;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX    = 2'd3;

    localparam logic [CENTER_W-1:0] CENTER_RST = 19'd225792;
    localparam logic [DEPTH_W-1:0]  DEPTH_RST  = 19'd56448;
    localparam logic [STEP_W-1:0]   STEP_RST   = 23'd304;
    localparam logic [MIX_W-1:0]    MIX_RST    = 17'd32768;

    // pi in q30
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // sin(x) for x in q30, 8-term taylor series, result in q15
    function automatic logic [SINE_W-1:0] sine_q15(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] s;
        logic signed [63:0] e;
        x2 = (x * x) >> 30;
        t  = x;
        s  = signed'(x);
        t  = ((t * x2) >> 30) / 64'd6;   s = s - signed'(t);
        t  = ((t * x2) >> 30) / 64'd20;  s = s + signed'(t);
        t  = ((t * x2) >> 30) / 64'd42;  s = s - signed'(t);
        t  = ((t * x2) >> 30) / 64'd72;  s = s + signed'(t);
        t  = ((t * x2) >> 30) / 64'd110; s = s - signed'(t);
        t  = ((t * x2) >> 30) / 64'd156; s = s + signed'(t);
        t  = ((t * x2) >> 30) / 64'd210; s = s - signed'(t);
        if (s < 64'sd0) s = 64'sd0;
        if (s > 64'sd1073741824) s = 64'sd1073741824;
        e = (s * 64'sd32767 + 64'sd536870912) >>> 30;
        if (e > 64'sd32767) e = 64'sd32767;
        return e[SINE_W-1:0];
    endfunction

endpackage

@@ rtl/core/cmd_sine_rom.sv @@
module cmd_sine_rom #(
    parameter int SINE_DEPTH = cmd_pkg::SINE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic [cmd_pkg::PHASE_W-1:0]  i_phase,
    output logic [cmd_pkg::SINE_W-1:0]   o_sine
);
    import cmd_pkg::*;

    localparam int SA_W = $clog2(SINE_DEPTH + 1);

    logic [SINE_W-1:0]   w_tab [SINE_DEPTH+1];
    logic [22+SA_W-1:0]  w_scaled;
    logic [SA_W-1:0]     w_idx;
    logic [SA_W-1:0]     r_addr;
    logic [SINE_W-1:0]   r_val;

    // quarter-wave table, built at elaboration
    for (genvar k = 0; k <= SINE_DEPTH; k++) begin : g_tab
        localparam logic [63:0] XK = (PI_Q30 * k) / (2 * SINE_DEPTH);
        localparam logic [SINE_W-1:0] VK = sine_q15(XK);
        assign w_tab[k] = VK;
    end

    assign w_scaled = (22 + SA_W)'(i_phase[21:0]) * (22 + SA_W)'(SINE_DEPTH);
    assign w_idx    = w_scaled[22 +: SA_W];

    // odd quadrants run the table backwards
    always_ff @(posedge i_clk) begin
        r_addr <= i_phase[22] ? (SA_W'(SINE_DEPTH) - w_idx) : w_idx;
        r_val  <= w_tab[r_addr];
    end

    assign o_sine = r_val;

endmodule

@@ rtl/core/cmd_mul.sv @@
module cmd_mul #(
    parameter int A_W = 20,
    parameter int B_W = 26
) (
    input  logic                        i_clk,
    input  logic signed [A_W-1:0]       i_a,
    input  logic signed [B_W-1:0]       i_b,
    output logic signed [A_W+B_W-1:0]   o_p
);
    logic signed [A_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= (A_W + B_W)'(i_a) * (A_W + B_W)'(i_b);
    end

    assign o_p = r_p;

endmodule

@@ rtl/core/cmd_ring.sv @@
module cmd_ring #(
    parameter int DEPTH = cmd_pkg::BUF_DEPTH_DEF,
    parameter int W     = cmd_pkg::SAMPLE_W_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  logic [W-1:0]              i_wdata,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [W-1:0]              o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/chorus_modulated_delay.sv @@
// channel   direction  handshake                  payload
// s (in)    slave      i_s_tvalid / o_s_tready    i_s_tdata: sample; i_s_tuser: func
// m (out)   master     o_m_tvalid / i_m_tready    o_m_tdata: out_sample
// cfg       write      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// a sample item runs the steps rom, sin, dly, adr, rda, rdb, inta, intb, mix and out from
// accept to the result register, one item at a time, set by the one shared multiplier
// (four products in turn) and the single read port of the ring
// a clear item, and reset itself, sweep the ring one entry a cycle, all with
// o_s_tready low; a clear item gives no result
// reset is synchronous, active low; the next item is taken while a result waits,
// and a finished item holds in its last step only while the result register is full
module chorus_modulated_delay #(
    parameter int BUF_DEPTH        = cmd_pkg::BUF_DEPTH_DEF,
    parameter int SINE_TABLE_DEPTH = cmd_pkg::SINE_DEPTH_DEF,
    parameter int SAMPLE_WIDTH     = cmd_pkg::SAMPLE_W_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     i_s_tdata,   // sample
    input  logic                                  i_s_tuser,   // func
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     o_m_tdata,   // out_sample
    input  logic                                  i_cfg_we,
    input  logic [cmd_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [cmd_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import cmd_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int TD_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int L     = $clog2(BUF_DEPTH);
    localparam int RP_W  = L + 10;
    localparam int SUM_W = (RP_W > 22) ? RP_W : 22;
    localparam int MA_W  = (SW > 20) ? SW : 20;
    localparam int MB_W  = SW + 10;
    localparam int P_W   = MA_W + MB_W;
    localparam int DL_W  = SW + 9;
    localparam int ACC_W = P_W + 1;
    localparam int Y_W   = ACC_W - 24;

    localparam logic signed [SUM_W-1:0] D_MIN    = SUM_W'(256);
    localparam logic signed [SUM_W-1:0] D_MAX    = SUM_W'((BUF_DEPTH - 2) * 256);
    localparam logic [RP_W-1:0]         BUF_SPAN = RP_W'(BUF_DEPTH * 256);
    localparam logic [L-1:0]            LAST_IDX = L'(BUF_DEPTH - 1);
    localparam logic signed [ACC_W-1:0] RND      = ACC_W'(8388608);
    localparam logic signed [Y_W-1:0]   SMAX     = Y_W'((1 << (SW - 1)) - 1);
    localparam logic signed [Y_W-1:0]   SMIN     = Y_W'(-(1 << (SW - 1)));

    // sequencer steps
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_ROM  = 4'd2;
    localparam logic [3:0] S_SIN  = 4'd3;
    localparam logic [3:0] S_DLY  = 4'd4;
    localparam logic [3:0] S_ADR  = 4'd5;
    localparam logic [3:0] S_RDA  = 4'd6;
    localparam logic [3:0] S_RDB  = 4'd7;
    localparam logic [3:0] S_INTA = 4'd8;
    localparam logic [3:0] S_INTB = 4'd9;
    localparam logic [3:0] S_MIX  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0]             r_state;
    logic [3:0]             n_state;

    // configuration
    logic [CENTER_W-1:0]    r_center;
    logic [DEPTH_W-1:0]     r_sweep;
    logic [STEP_W-1:0]      r_step;
    logic [MIX_W-1:0]       r_mix;

    // item state
    logic [L-1:0]           r_wp;
    logic [PHASE_W-1:0]     r_phase;
    logic [L-1:0]           r_clr_cnt;

    // datapath registers
    logic signed [SW-1:0]   r_x;
    logic [RP_W-1:0]        r_delay;
    logic [L-1:0]           r_i0;
    logic [7:0]             r_frac;
    logic signed [DL_W-1:0] r_acc;
    logic signed [MB_W-1:0] r_diff;
    logic                   r_m_valid;
    logic [SW-1:0]          r_m_data;

    logic                   w_accept;
    logic                   w_out_go;
    logic [SINE_W-1:0]      w_sine_mag;
    logic signed [16:0]     w_sine;
    logic signed [MA_W-1:0] w_mul_a;
    logic signed [MB_W-1:0] w_mul_b;
    logic signed [P_W-1:0]  w_prod;
    logic [8:0]             w_nfrac;
    logic signed [SUM_W-1:0] w_cen;
    logic signed [SUM_W-1:0] w_mod;
    logic signed [SUM_W-1:0] w_dsum;
    logic signed [SUM_W-1:0] w_dcl;
    logic [RP_W-1:0]        w_rp;
    logic [RP_W-1:0]        w_rpw;
    logic [L-1:0]           w_i1;
    logic signed [DL_W-1:0] w_pb;
    logic signed [MB_W-1:0] w_x256;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [Y_W-1:0]  w_y;
    logic [SW-1:0]          w_ysat;
    logic                   w_ring_we;
    logic [L-1:0]           w_ring_waddr;
    logic [SW-1:0]          w_ring_wdata;
    logic [L-1:0]           w_ring_raddr;
    logic [SW-1:0]          w_ring_rdata;

    assign w_accept = i_s_tvalid && o_s_tready;
    // result register must be free (or emptying) before the last step retires
    assign w_out_go = (r_state == S_OUT) && (!r_m_valid || i_m_tready);

    // ---------------- lfo sine lookup (two-stage table read) ----------------
    cmd_sine_rom #(
        .SINE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk   (i_clk),
        .i_phase (r_phase),
        .o_sine  (w_sine_mag)
    );

    // upper half of the turn is negative
    assign w_sine = r_phase[23] ? -$signed({2'b00, w_sine_mag})
                                :  $signed({2'b00, w_sine_mag});

    // ---------------- shared multiplier and its operand select ----------------
    assign w_nfrac = 9'd256 - {1'b0, r_frac};

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_SIN: begin
                // modulation depth times sine
                w_mul_a = MA_W'(r_sweep);
                w_mul_b = MB_W'(w_sine);
            end
            S_RDB: begin
                // older tap weighted by 256 - frac
                w_mul_a = MA_W'($signed(w_ring_rdata));
                w_mul_b = MB_W'(w_nfrac);
            end
            S_INTA: begin
                // newer tap weighted by frac
                w_mul_a = MA_W'($signed(w_ring_rdata));
                w_mul_b = MB_W'(r_frac);
            end
            S_MIX, S_OUT: begin
                // wet share times (delayed - dry), kept up while the last step waits
                w_mul_a = MA_W'(r_mix);
                w_mul_b = r_diff;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    cmd_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // ---------------- delay, read position ----------------
    assign w_cen  = SUM_W'(r_center);
    assign w_mod  = SUM_W'(w_prod >>> 15);   // arithmetic shift floors
    assign w_dsum = w_cen + w_mod;

    always_comb begin
        w_dcl = w_dsum;
        if (w_dsum < D_MIN) w_dcl = D_MIN;
        if (w_dsum > D_MAX) w_dcl = D_MAX;
    end

    // read position behind the write pointer, wrapped once
    assign w_rp  = RP_W'({r_wp, 8'b0}) + BUF_SPAN - r_delay;
    assign w_rpw = (w_rp >= BUF_SPAN) ? (w_rp - BUF_SPAN) : w_rp;
    assign w_i1  = (r_i0 == LAST_IDX) ? '0 : (r_i0 + L'(1));

    // ---------------- interpolation and mix ----------------
    assign w_pb   = w_prod[DL_W-1:0];
    assign w_x256 = MB_W'(r_x) <<< 8;

    assign w_acc = (ACC_W'(r_x) <<< 24) + ACC_W'(w_prod) + RND;
    assign w_y   = w_acc[ACC_W-1:24];

    always_comb begin
        w_ysat = w_y[SW-1:0];
        if (w_y > SMAX) w_ysat = SMAX[SW-1:0];
        if (w_y < SMIN) w_ysat = SMIN[SW-1:0];
    end

    // ---------------- delay ring ----------------
    assign w_ring_we    = (r_state == S_CLR) || w_out_go;
    assign w_ring_waddr = (r_state == S_CLR) ? r_clr_cnt : r_wp;
    assign w_ring_wdata = (r_state == S_CLR) ? '0 : r_x;
    assign w_ring_raddr = (r_state == S_RDB) ? w_i1 : r_i0;

    cmd_ring #(
        .DEPTH (BUF_DEPTH),
        .W     (SW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ring_we),
        .i_waddr (w_ring_waddr),
        .i_wdata (w_ring_wdata),
        .i_raddr (w_ring_raddr),
        .o_rdata (w_ring_rdata)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  if (r_clr_cnt == LAST_IDX) n_state = S_IDLE;
            S_IDLE: begin
                if (w_accept) n_state = i_s_tuser ? S_CLR : S_ROM;
            end
            S_ROM:  n_state = S_SIN;
            S_SIN:  n_state = S_DLY;
            S_DLY:  n_state = S_ADR;
            S_ADR:  n_state = S_RDA;
            S_RDA:  n_state = S_RDB;
            S_RDB:  n_state = S_INTA;
            S_INTA: n_state = S_INTB;
            S_INTB: n_state = S_MIX;
            S_MIX:  n_state = S_OUT;
            S_OUT:  if (w_out_go) n_state = S_IDLE;
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_cnt <= '0;
            r_wp      <= '0;
            r_phase   <= '0;
            r_m_valid <= 1'b0;
            r_center  <= CENTER_RST;
            r_sweep   <= DEPTH_RST;
            r_step    <= STEP_RST;
            r_mix     <= MIX_RST;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CENTER: r_center <= i_cfg_data[CENTER_W-1:0];
                    CFG_DEPTH:  r_sweep  <= i_cfg_data[DEPTH_W-1:0];
                    CFG_STEP:   r_step   <= i_cfg_data[STEP_W-1:0];
                    CFG_MIX:    r_mix    <= i_cfg_data[MIX_W-1:0];
                    default: ;
                endcase
            end

            // clear item restarts the sweep and the lfo
            if (r_state == S_IDLE && w_accept && i_s_tuser) begin
                r_clr_cnt <= '0;
                r_wp      <= '0;
                r_phase   <= '0;
            end else if (r_state == S_CLR) begin
                r_clr_cnt <= r_clr_cnt + L'(1);
            end

            if (w_out_go) begin
                r_wp    <= (r_wp == LAST_IDX) ? '0 : (r_wp + L'(1));
                r_phase <= r_phase + PHASE_W'(r_step);
            end

            if (w_out_go) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) r_x <= $signed(i_s_tdata[SW-1:0]);
        if (r_state == S_DLY) r_delay <= w_dcl[RP_W-1:0];
        if (r_state == S_ADR) begin
            r_i0   <= w_rpw[8 +: L];
            r_frac <= w_rpw[7:0];
        end
        if (r_state == S_INTA) r_acc <= w_prod[DL_W-1:0];
        if (r_state == S_INTB) r_diff <= MB_W'(r_acc) + MB_W'(w_pb) - w_x256;
        if (w_out_go) r_m_data <= w_ysat;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = TD_W'(r_m_data);

endmodule

@@ rtl/core/chorus_modulated_delay_chk.sv @@
`include "chorus_modulated_delay_assert.svh"

module chorus_modulated_delay_chk #(
    parameter int SAMPLE_WIDTH = cmd_pkg::SAMPLE_W_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    input  logic                               o_s_tready,
    input  logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  o_m_tdata
);
    import cmd_pkg::*;

    // a held result stays up
    `CMD_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid, "result dropped while stalled")

    // a held result keeps its value
    `CMD_ASSERT_NEXT(a_out_stable, o_m_tvalid && !i_m_tready, $stable(o_m_tdata), "result changed while stalled")

    // one item at a time: intake closes right after an accept
    `CMD_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && o_s_tready, !o_s_tready, "ready stayed high after accept")

    // no result can appear the cycle after an item is taken
    `CMD_ASSERT_NEXT(a_no_early_result, i_s_tvalid && o_s_tready, !$rose(o_m_tvalid), "result too early")

endmodule

bind chorus_modulated_delay chorus_modulated_delay_chk #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_chk (.*);

@@ sim/chorus_modulated_delay_tb.sv @@
`timescale 1ns / 1ps

module chorus_modulated_delay_tb;

    import cmd_pkg::*;

    localparam int SW     = SAMPLE_W_DEF;
    localparam int TDW    = ((SW + 7) / 8) * 8;
    localparam int RING_N = BUF_DEPTH_DEF;
    localparam int SINE_N = SINE_DEPTH_DEF;

    // item kinds carried on tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic                 func;
        logic signed [SW-1:0] smp;
    } sample_item_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // block inputs, all known from time zero
    logic                 s_valid  = 1'b0;
    logic [TDW-1:0]       s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_ready  = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                 s_ready;
    logic                 m_valid;
    logic [TDW-1:0]       m_tdata;

    chorus_modulated_delay dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_tdata),    // sample
        .i_s_tuser  (s_tuser),    // func
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_tdata),    // out_sample
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // predictor state: its own copy of the ring, pointer, lfo and registers
    // ------------------------------------------------------------------
    logic signed [SW-1:0] echo_ring [RING_N];
    int                   echo_wr;
    logic [PHASE_W-1:0]   lfo_acc;
    logic [CENTER_W-1:0]  cfg_center;
    logic [DEPTH_W-1:0]   cfg_depth;
    logic [STEP_W-1:0]    cfg_step;
    logic [MIX_W-1:0]     cfg_mix;
    int                   qsine [0:SINE_N];

    sample_item_t         pending [$];     // items waiting for the driver
    logic signed [SW-1:0] out_expect [$];  // predicted output samples, oldest first

    // run bookkeeping
    int mismatches    = 0;
    int items_sent    = 0;
    int clears_sent   = 0;
    int results_seen  = 0;
    int settings_used = 0;

    // idling controls, changed per phase
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    int src_hold     = 0;
    int sink_hold    = 0;

    task automatic report_mismatch(input string what);
        $display("  mismatch at result %0d: %s", results_seen, what);
        mismatches++;
    endtask

    // quarter-wave sine in q15, taylor series in q30 with truncating steps,
    // then rounded half up
    function automatic void build_quarter_sine();
        longint unsigned x, x2, t;
        longint          s, e;
        for (int k = 0; k <= SINE_N; k++) begin
            x  = (PI_Q30 * longint'(k)) / (2 * SINE_N);
            x2 = (x * x) >> 30;
            t  = x;
            s  = longint'(x);
            for (int n = 1; n <= 7; n++) begin
                t = ((t * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    s = s - longint'(t);
                else
                    s = s + longint'(t);
            end
            if (s < 0)
                s = 0;
            if (s > (longint'(1) << 30))
                s = longint'(1) << 30;
            e = (s * 32767 + (longint'(1) << 29)) >>> 30;
            if (e > 32767)
                e = 32767;
            qsine[k] = int'(e);
        end
    endfunction

    // top two phase bits pick the quadrant, the rest index the table
    function automatic int lfo_sine(input logic [PHASE_W-1:0] ph);
        int     v;
        longint idx;
        idx = (longint'(ph[PHASE_W-3:0]) * SINE_N) >> (PHASE_W - 2);
        v   = ph[PHASE_W-2] ? qsine[SINE_N - idx] : qsine[idx];
        return ph[PHASE_W-1] ? -v : v;
    endfunction

    function automatic void reset_model();
        foreach (echo_ring[k])
            echo_ring[k] = '0;
        echo_wr    = 0;
        lfo_acc    = '0;
        cfg_center = CENTER_RST;
        cfg_depth  = DEPTH_RST;
        cfg_step   = STEP_RST;
        cfg_mix    = MIX_RST;
        build_quarter_sine();
    endfunction

    // one accepted item: update the model and queue the expected output
    function automatic void predict_chorus(input sample_item_t it);
        longint x, dly, rp, frac, a, b, wet, acc, y;
        int     i0, i1;
        items_sent++;
        if (it.func == OP_CLEAR) begin
            foreach (echo_ring[k])
                echo_ring[k] = '0;
            echo_wr = 0;
            lfo_acc = '0;
            clears_sent++;
            return;
        end
        x = it.smp;

        // modulated delay, 8 fraction bits, held inside the ring
        dly = longint'(cfg_center) + ((longint'(cfg_depth) * lfo_sine(lfo_acc)) >>> 15);
        if (dly < 256)
            dly = 256;
        if (dly > longint'(RING_N - 2) * 256)
            dly = longint'(RING_N - 2) * 256;

        // read position behind the write pointer, wrapped
        rp = longint'(echo_wr) * 256 + longint'(RING_N) * 256 - dly;
        if (rp >= longint'(RING_N) * 256)
            rp = rp - longint'(RING_N) * 256;
        i0   = int'((rp >> 8) % RING_N);
        i1   = (i0 + 1 == RING_N) ? 0 : i0 + 1;
        frac = rp & 255;
        a    = echo_ring[i0];
        b    = echo_ring[i1];
        wet  = a * (256 - frac) + b * frac;

        // dry/wet blend, round to nearest with ties up, then clip
        acc = x * (longint'(1) << 24) + longint'(cfg_mix) * (wet - x * 256)
              + (longint'(1) << 23);
        y = acc >>> 24;
        if (y > (longint'(1) << (SW - 1)) - 1)
            y = (longint'(1) << (SW - 1)) - 1;
        if (y < -(longint'(1) << (SW - 1)))
            y = -(longint'(1) << (SW - 1));
        out_expect.push_back(y[SW-1:0]);

        echo_ring[echo_wr] = it.smp;
        echo_wr = (echo_wr + 1 == RING_N) ? 0 : echo_wr + 1;
        lfo_acc = lfo_acc + PHASE_W'(cfg_step);
    endfunction

    // ------------------------------------------------------------------
    // driver: feeds pending items, draws a gap after each one
    // ------------------------------------------------------------------
    sample_item_t cur_item;

    always @(posedge clk) begin : feed
        sample_item_t nxt;
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else begin
            // item taken at this edge goes through the predictor
            if (s_valid && s_ready)
                predict_chorus(cur_item);
            if (!s_valid || s_ready) begin
                if (src_hold > 0) begin
                    src_hold--;
                    s_valid <= 1'b0;
                end else if (pending.size() != 0) begin
                    nxt      = pending.pop_front();
                    cur_item = nxt;
                    s_valid  <= 1'b1;
                    s_tdata  <= TDW'(nxt.smp);
                    s_tuser  <= nxt.func;
                    src_hold = src_idle_on ? $urandom_range(0, 15) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: compares each output item with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin : sink
        logic signed [SW-1:0] want;
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (out_expect.size() == 0) begin
                    report_mismatch($sformatf("output %0d with nothing expected",
                                              $signed(m_tdata[SW-1:0])));
                end else begin
                    want = out_expect.pop_front();
                    if (m_tdata[SW-1:0] !== want)
                        report_mismatch($sformatf("out_sample %0d, expected %0d",
                                                  $signed(m_tdata[SW-1:0]), want));
                end
                results_seen++;
                sink_hold = sink_idle_on ? $urandom_range(0, 15) : 0;
            end else if (sink_hold > 0) begin
                sink_hold--;
            end
            m_ready <= (sink_hold == 0);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send(input logic func, input logic signed [SW-1:0] smp);
        sample_item_t it;
        it.func = func;
        it.smp  = smp;
        pending.push_back(it);
    endtask

    // block until every queued item is in and every result is out
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending.size() != 0 || s_valid || out_expect.size() != 0);
    endtask

    // write all four registers while the block is idle; a clear item leaves
    // no result behind, so wait out a full ring sweep first
    task automatic load_config(input logic [CFG_DATA_W-1:0] c, input logic [CFG_DATA_W-1:0] d,
                               input logic [CFG_DATA_W-1:0] st,
                               input logic [CFG_DATA_W-1:0] m);
        logic [CFG_DATA_W-1:0] vals [4];
        logic [CFG_IDX_W-1:0]  regs [4];
        vals = '{c, d, st, m};
        regs = '{CFG_CENTER, CFG_DEPTH, CFG_STEP, CFG_MIX};
        wait_drained();
        repeat (RING_N + 16) @(posedge clk);
        for (int i = 0; i < 4; i++) begin
            @(posedge clk);
            cfg_we   <= 1'b1;
            cfg_idx  <= regs[i];
            cfg_data <= vals[i];
            // model takes the value masked to the register width
            case (regs[i])
                CFG_CENTER: cfg_center = vals[i][CENTER_W-1:0];
                CFG_DEPTH:  cfg_depth  = vals[i][DEPTH_W-1:0];
                CFG_STEP:   cfg_step   = vals[i][STEP_W-1:0];
                CFG_MIX:    cfg_mix    = vals[i][MIX_W-1:0];
                default: ;
            endcase
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // extremes often, small values and full-range noise otherwise
    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return {1'b0, {(SW-1){1'b1}}};
            1:       return {1'b1, {(SW-1){1'b0}}};
            2:       return SW'(int'($urandom_range(0, 512)) - 256);
            default: return SW'($urandom);
        endcase
    endfunction

    // random register values: mostly short delays so the ring is read back
    // with real data, sometimes anything the field width allows
    task automatic random_phase(input int n_items);
        logic [CFG_DATA_W-1:0] c, d, st, m;
        case ($urandom_range(0, 3))
            0:       c = CFG_DATA_W'($urandom);
            1:       c = CFG_DATA_W'(256);
            default: c = CFG_DATA_W'($urandom_range(256, 80 * 256));
        endcase
        case ($urandom_range(0, 3))
            0:       d = CFG_DATA_W'($urandom);
            1:       d = '0;
            default: d = CFG_DATA_W'($urandom_range(0, 40 * 256));
        endcase
        case ($urandom_range(0, 3))
            0:       st = CFG_DATA_W'($urandom);
            1:       st = '0;
            default: st = CFG_DATA_W'($urandom_range(0, 1 << 20));
        endcase
        case ($urandom_range(0, 3))
            0:       m = CFG_DATA_W'($urandom);
            1:       m = CFG_DATA_W'(65536);
            default: m = CFG_DATA_W'($urandom_range(0, 65536));
        endcase
        load_config(c, d, st, m);
        src_idle_on  = ($urandom_range(0, 2) != 0);
        sink_idle_on = ($urandom_range(0, 2) != 0);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < 2)
                send(OP_CLEAR, SW'($urandom));
            else
                send(OP_SAMPLE, pick_sample());
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        reset_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values: long delay, ring still empty, half wet
        send(OP_SAMPLE, 16'sh7FFF);
        send(OP_SAMPLE, 16'sh8000);
        send(OP_SAMPLE, 16'sh0000);
        send(OP_SAMPLE, 16'shFFFF);
        send(OP_SAMPLE, 16'sh0001);
        send(OP_CLEAR,  16'sh0000);
        send(OP_SAMPLE, 16'sh7FFF);

        // one-sample delay, fully wet: each output is the previous input
        load_config(23'd256, 23'd0, 23'd0, 23'd65536);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send(OP_SAMPLE, 16'sh7FFF);
        send(OP_SAMPLE, 16'sh8000);
        send(OP_SAMPLE, 16'sh7FFF);
        send(OP_SAMPLE, 16'shFFFF);
        send(OP_SAMPLE, 16'sh0000);
        send(OP_SAMPLE, 16'sh0001);

        // quarter-turn lfo steps over a deep sweep: low clamp, mix past
        // full wet so the output extrapolates and clips
        load_config(23'd0, 23'd523776, 23'h400000, 23'h01FFFF);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send(OP_SAMPLE, 16'sh7FFF);
        send(OP_SAMPLE, 16'sh8000);
        send(OP_SAMPLE, 16'sh7FFF);
        send(OP_SAMPLE, 16'sh8000);
        send(OP_SAMPLE, 16'sh3039);
        send(OP_SAMPLE, 16'shFFFF);

        // all-ones writes: masked to width, high clamp, largest step, mix past full wet
        load_config(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF);
        send(OP_SAMPLE, 16'sh8000);
        send(OP_SAMPLE, 16'sh7FFF);
        send(OP_SAMPLE, 16'sh5A5A);
        send(OP_SAMPLE, 16'shA5A5);

        load_config(23'd0, 23'd0, 23'd0, 23'd0);
        send(OP_SAMPLE, 16'sh1234);
        send(OP_SAMPLE, 16'shEDCB);

        // random part, a fresh register setting per phase
        for (int p = 0; p < 8; p++)
            random_phase(90);

        wait_drained();
        repeat (32) @(posedge clk);

        $display("run covered %0d items (%0d ring clears) over %0d register settings",
                 items_sent, clears_sent, settings_used);
        $display("%0d output items checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("chorus_modulated_delay test passed");
        else
            $display("chorus_modulated_delay test failed");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", out_expect.size());
        $display("chorus_modulated_delay test failed");
        $finish;
    end

endmodule
